// ===== rtl/evq_pkg.sv =====
// shared types, constants and helpers of the event queue with statistics
package evq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int EVENT_TYPES = 16;

   localparam int ID_W    = 4;
   localparam int AUX_W   = 32;
   localparam int CNT_W   = 32;
   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CNT_AW  = (EVENT_TYPES > 1) ? $clog2(EVENT_TYPES) : 1;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   localparam logic [ID_W-1:0] ID_VOID = '0;

   typedef struct packed {
      logic             op;
      logic [ID_W-1:0]  event_id;
      logic [AUX_W-1:0] aux_data;
   } req_type;

   typedef struct packed {
      logic             ok;
      logic [ID_W-1:0]  out_event_id;
      logic [AUX_W-1:0] out_aux_data;
      logic [CNT_W-1:0] enqueue_count;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]  event_id;
      logic [AUX_W-1:0] aux_data;
   } entry_type;

   // lookup at request accept, increment when the enqueue completes
   typedef struct packed {
      logic            rd;
      logic [ID_W-1:0] rd_id;
      logic            inc;
      logic [ID_W-1:0] id;
   } stats_cmd_type;

   function automatic logic [CNT_AW-1:0] cnt_index(input logic [ID_W-1:0] id);
      logic [CNT_AW+ID_W-1:0] wide;
      wide = {{CNT_AW{1'b0}}, id};
      return wide[CNT_AW-1:0];
   endfunction

   function automatic logic has_counter(input logic [ID_W-1:0] id);
      logic [CNT_AW+ID_W-1:0] wide;
      wide = {{CNT_AW{1'b0}}, id};
      return wide < (CNT_AW + ID_W)'(EVENT_TYPES);
   endfunction

endpackage

// ===== rtl/evq_ram.sv =====
// generic single write port ram with registered read
module evq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH)-1:0]         waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic                             re,
   input  logic [$clog2(DEPTH)-1:0]         raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/evq_stats.sv =====
// per-id enqueue counters in a ram plus the total counter
module evq_stats (
   input  logic                          clock,
   input  logic                          reset,
   input  evq_pkg::stats_cmd_type        cmd,
   output logic [evq_pkg::CNT_W-1:0]     count
);

   import evq_pkg::*;

   logic [EVENT_TYPES-1:0] valid_ff;
   logic [EVENT_TYPES-1:0] valid_in;
   logic [CNT_W-1:0]       total_ff;
   logic [CNT_W-1:0]       total_in;
   logic [CNT_W-1:0]       rdata;
   logic [CNT_W-1:0]       cur;
   logic [CNT_W-1:0]       cur_next;
   logic [CNT_AW-1:0]      idx;
   logic                   own;
   logic                   we;

   assign idx      = cnt_index(cmd.id);
   assign own      = has_counter(cmd.id) && (cmd.id != ID_VOID);
   assign cur      = valid_ff[idx] ? rdata : '0;
   assign cur_next = cur + CNT_W'(cmd.inc);
   assign we       = cmd.inc && own;

   evq_ram #(
      .WIDTH (CNT_W),
      .DEPTH (EVENT_TYPES)
   ) u_cnt_ram (
      .clock (clock),
      .we    (we),
      .waddr (idx),
      .wdata (cur_next),
      .re    (cmd.rd),
      .raddr (cnt_index(cmd.rd_id)),
      .rdata (rdata)
   );

   always_comb begin
      valid_in = valid_ff;
      total_in = total_ff;
      if (cmd.inc) begin
         total_in = total_ff + CNT_W'(1);
      end
      if (we) begin
         valid_in[idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         total_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         total_ff <= total_in;
      end
   end

   // count after this request's update
   always_comb begin
      if (cmd.id == ID_VOID) begin
         count = total_in;
      end else if (own) begin
         count = cur_next;
      end else begin
         count = '0;
      end
   end

endmodule

// ===== rtl/event_fifo_with_statistics_top.sv =====
// top level: circular event queue with enqueue statistics
//
//   channel  | direction | handshake              | payload
//   req      | in        | req_valid / req_ready  | req_data (op, event_id, aux_data)
//   rsp      | out       | rsp_valid / rsp_ready  | rsp_data (ok, event, count, overflow)
//
// each request is accepted with ram lookups in S_IDLE, then updated and written back in S_EXEC
// one response per request, held in an output register until taken
// a new request is accepted while the previous response still waits
// a pending update stalls only while the output register is full
// synchronous active-high reset empties the queue and clears all counters
module event_fifo_with_statistics_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  evq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output evq_pkg::rsp_type  rsp_data
);

   import evq_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic               state_ff;
   logic               state_in;
   req_type            req_q_ff;
   req_type            req_q_in;
   logic [PTR_W-1:0]   head_ff;
   logic [PTR_W-1:0]   head_in;
   logic [PTR_W-1:0]   tail_ff;
   logic [PTR_W-1:0]   tail_in;
   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] level_in;
   logic               overflow_ff;
   logic               overflow_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic               accept;
   logic               go;
   logic               full;
   logic               empty;
   logic               enq_ok;
   logic               ext_ok;
   entry_type          q_wdata;
   entry_type          q_rdata;
   stats_cmd_type      stats_cmd;
   logic [CNT_W-1:0]   count;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign go        = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign full      = (level_ff == LEVEL_W'(QUEUE_DEPTH));
   assign empty     = (level_ff == '0);
   assign enq_ok    = go && (req_q_ff.op == OP_ENQUEUE) && !full;
   assign ext_ok    = go && (req_q_ff.op == OP_EXTRACT) && !empty;

   assign q_wdata.event_id = req_q_ff.event_id;
   assign q_wdata.aux_data = req_q_ff.aux_data;

   evq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock (clock),
      .we    (enq_ok),
      .waddr (tail_ff),
      .wdata (q_wdata),
      .re    (accept),
      .raddr (head_ff),
      .rdata (q_rdata)
   );

   assign stats_cmd.rd    = accept;
   assign stats_cmd.rd_id = req_data.event_id;
   assign stats_cmd.inc   = enq_ok;
   assign stats_cmd.id    = req_q_ff.event_id;

   evq_stats u_stats (
      .clock (clock),
      .reset (reset),
      .cmd   (stats_cmd),
      .count (count)
   );

   always_comb begin
      state_in     = state_ff;
      req_q_in     = req_q_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      level_in     = level_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_q_in = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (go) begin
               rsp_in.ok            = enq_ok || ext_ok;
               rsp_in.out_event_id  = '0;
               rsp_in.out_aux_data  = '0;
               rsp_in.enqueue_count = count;
               if (enq_ok) begin
                  tail_in  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
                  level_in = level_ff + LEVEL_W'(1);
               end else if (ext_ok) begin
                  head_in  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
                  level_in = level_ff - LEVEL_W'(1);
                  rsp_in.out_event_id = q_rdata.event_id;
                  rsp_in.out_aux_data = q_rdata.aux_data;
               end else if (req_q_ff.op == OP_ENQUEUE) begin
                  overflow_in = 1'b1;
               end
               rsp_in.overflow = overflow_in;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         level_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         level_ff     <= level_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_q_ff <= req_q_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(QUEUE_DEPTH))
      else $error("fill level beyond queue depth");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared without reset");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC) && !req_ready)
      else $error("accepted request did not move to execute");

   a_enq_level: assert property (@(posedge clock) disable iff (reset)
      enq_ok |=> level_ff == $past(level_ff) + LEVEL_W'(1))
      else $error("enqueue did not raise the fill level");

   a_rsp_follows_go: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("completed request left no response");
`endif

endmodule
